// ===== sv/lrf_pkg.sv =====
// Shared types and constants for the streaming least-squares line fit.
package lrf_pkg;

   localparam int MAX_POINTS = 65536;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int SX_W       = 33;
   localparam int SXY_W      = 48;
   localparam int SXX_W      = 47;
   localparam int A_W        = 48;
   localparam int B_W        = 34;
   localparam int BMAG_W     = B_W - 1;
   localparam int ACC_W      = 84;
   localparam int DIV_W      = ACC_W + 16;
   localparam int DCNT_W     = $clog2(DIV_W);
   localparam int DEN_W      = 64;
   localparam int Q_W        = 33;

   localparam logic [2:0] OP_N_SXX   = 3'd0;
   localparam logic [2:0] OP_SX_SX   = 3'd1;
   localparam logic [2:0] OP_SY_SXX  = 3'd2;
   localparam logic [2:0] OP_SX_SXY  = 3'd3;
   localparam logic [2:0] OP_N_SXY   = 3'd4;
   localparam logic [2:0] OP_SX_SY   = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_SAT      = 2'd2;
   localparam logic [1:0] ST_TOO_MANY = 2'd3;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_LOAD  = 7'b0000010,
      S_MAC   = 7'b0000100,
      S_DIVLD = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_DSAVE = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic       mac_load;
      logic       acc_clear;
      logic [2:0] op;
      logic       mac_step;
      logic       save_den;
      logic       save_ni;
      logic       div_load;
      logic       div_sel;
      logic       div_step;
      logic       div_save;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic mac_busy;
      logic den_zero;
   } stat_type;

endpackage

// ===== sv/linear_regression_fit.sv =====
// Sequence: after the last point's transfer, the result valid rises once six bit-serial
// products and two restoring divisions are done; on a zero denominator the divisions
// are skipped.
// Throughput: one point per cycle; input stalls while a fit runs, and a last point
// waits while a previous result is still untaken.
// Reset (synchronous, active high) clears the sums, the sequencer and the result valid.
module linear_regression_fit import lrf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_x_sample,
   input  logic signed [15:0] req_y_sample,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_intercept,
   output logic signed [31:0] rsp_slope,
   output logic [1:0]         rsp_fit_status
);

   cmd_type  cmd;
   stat_type stat;
   logic     idle, take;

   assign req_stall = !idle || (req_last_point && rsp_valid);
   assign take      = req_valid && !req_stall;

   lrf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (take && req_last_point),
      .stat  (stat),
      .cmd   (cmd),
      .idle  (idle)
   );

   lrf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .x_sample       (req_x_sample),
      .y_sample       (req_y_sample),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_intercept  (rsp_intercept),
      .rsp_slope      (rsp_slope),
      .rsp_fit_status (rsp_fit_status)
   );

endmodule

// ===== sv/lrf_ctrl.sv =====
// Fit sequencer: steps the multiply-accumulate and divide phases.
module lrf_ctrl import lrf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     idle
);

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic              sel_ff, sel_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;

   assign idle = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.op      = op_ff;
      cmd.div_sel = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = OP_N_SXX;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.mac_load  = 1'b1;
            cmd.acc_clear = ~op_ff[0];
            state_in      = S_MAC;
         end
         S_MAC: begin
            if (stat.mac_busy) begin
               cmd.mac_step = 1'b1;
            end else begin
               cmd.save_den = (op_ff == OP_SX_SX);
               cmd.save_ni  = (op_ff == OP_SX_SXY);
               if (op_ff == OP_SX_SY) begin
                  sel_in   = 1'b0;
                  state_in = stat.den_zero ? S_DONE : S_DIVLD;
               end else begin
                  op_in    = op_ff + 3'd1;
                  state_in = S_LOAD;
               end
            end
         end
         S_DIVLD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(DIV_W - 1)) state_in = S_DSAVE;
         end
         S_DSAVE: begin
            cmd.div_save = 1'b1;
            if (sel_ff) begin
               state_in = S_DONE;
            end else begin
               sel_in   = 1'b1;
               state_in = S_DIVLD;
            end
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_N_SXX;
         sel_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_op_range: assert property (@(posedge clock) disable iff (reset) op_ff <= OP_SX_SY)
      else $error("op index out of range");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DSAVE |-> $past(cnt_ff) == DCNT_W'(DIV_W - 1))
      else $error("division ended early");

endmodule

// ===== sv/lrf_dp.sv =====
// Datapath: running sums, bit-serial multiply-accumulate, restoring divider, result register.
module lrf_dp import lrf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic signed [15:0] x_sample,
   input  logic signed [15:0] y_sample,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_intercept,
   output logic signed [31:0] rsp_slope,
   output logic [1:0]         rsp_fit_status
);

   logic [CNT_W-1:0]        cnt_ff;
   logic signed [SX_W-1:0]  sx_ff, sy_ff;
   logic signed [SXY_W-1:0] sxy_ff;
   logic [SXX_W-1:0]        sxx_ff;
   logic                    ovf_ff;

   logic signed [ACC_W-1:0] acc_ff, ni_ff;
   logic [ACC_W-1:0]        ash_ff;
   logic [BMAG_W-1:0]       bmag_ff;
   logic                    msign_ff;
   logic [DEN_W-1:0]        den_ff;

   logic [DIV_W-1:0]        dvd_ff;
   logic [DEN_W-1:0]        rem_ff;
   logic [Q_W-1:0]          q_ff;
   logic                    sticky_ff, dneg_ff, sat_ff;
   logic [31:0]             icpt_ff, slp_ff;

   logic                    rv_ff;
   logic [31:0]             ri_ff, rs_ff;
   logic [1:0]              rst_ff;

   logic signed [31:0]      xy;
   logic [31:0]             xx;
   logic signed [A_W-1:0]   a_op;
   logic signed [B_W-1:0]   b_op;
   logic                    neg_op;
   logic [A_W-1:0]          amag;
   logic [B_W-1:0]          bmag;
   logic signed [ACC_W-1:0] num, nmag;
   logic [DEN_W:0]          rem_sh, rem_sub;
   logic                    qbit;
   logic [31:0]             qres, limit;
   logic                    qovf;
   logic [1:0]              status;

   function automatic logic [31:0] xy_sq(input logic signed [15:0] v);
      logic signed [31:0] p;
      p = v * v;
      return p;
   endfunction

   assign xy = x_sample * y_sample;
   assign xx = 32'(xy_sq(x_sample));

   always_comb begin
      case (cmd.op)
         OP_N_SXX:  begin a_op = A_W'(sxx_ff);  b_op = B_W'(cnt_ff); neg_op = 1'b0; end
         OP_SX_SX:  begin a_op = A_W'(sx_ff);   b_op = B_W'(sx_ff);  neg_op = 1'b1; end
         OP_SY_SXX: begin a_op = A_W'(sxx_ff);  b_op = B_W'(sy_ff);  neg_op = 1'b0; end
         OP_SX_SXY: begin a_op = sxy_ff;        b_op = B_W'(sx_ff);  neg_op = 1'b1; end
         OP_N_SXY:  begin a_op = sxy_ff;        b_op = B_W'(cnt_ff); neg_op = 1'b0; end
         OP_SX_SY:  begin a_op = A_W'(sy_ff);   b_op = B_W'(sx_ff);  neg_op = 1'b1; end
         default:   begin a_op = '0;            b_op = '0;           neg_op = 1'b0; end
      endcase
      if (cmd.op == OP_N_SXX || cmd.op == OP_N_SXY) b_op = B_W'({1'b0, cnt_ff});
      amag = a_op[A_W-1] ? A_W'(-a_op) : A_W'(a_op);
      bmag = b_op[B_W-1] ? B_W'(-b_op) : B_W'(b_op);
   end

   always_comb begin
      num  = cmd.div_sel ? acc_ff : ni_ff;
      nmag = num[ACC_W-1] ? -num : num;
      rem_sh  = {rem_ff, dvd_ff[DIV_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      qbit    = (rem_sh >= {1'b0, den_ff});
      limit   = dneg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      qovf    = sticky_ff || q_ff[Q_W-1] || (q_ff[31:0] > limit);
      if (qovf) qres = dneg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else qres = dneg_ff ? (32'd0 - q_ff[31:0]) : q_ff[31:0];
      if (ovf_ff) status = ST_TOO_MANY;
      else if (den_ff == '0) status = ST_ZERO_DEN;
      else if (sat_ff) status = ST_SAT;
      else status = ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxy_ff <= '0;
         sxx_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.finish) begin
         cnt_ff <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxy_ff <= '0;
         sxx_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (take) begin
         if (cnt_ff == CNT_W'(MAX_POINTS)) begin
            ovf_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
            sx_ff  <= sx_ff + SX_W'(x_sample);
            sy_ff  <= sy_ff + SX_W'(y_sample);
            sxy_ff <= sxy_ff + SXY_W'(xy);
            sxx_ff <= sxx_ff + SXX_W'(xx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_load) begin
         if (cmd.acc_clear) acc_ff <= '0;
         ash_ff   <= ACC_W'(amag);
         bmag_ff  <= bmag[BMAG_W-1:0];
         msign_ff <= a_op[A_W-1] ^ b_op[B_W-1] ^ neg_op;
      end else if (cmd.mac_step) begin
         if (bmag_ff[0]) acc_ff <= msign_ff ? acc_ff - ash_ff : acc_ff + ash_ff;
         ash_ff  <= ash_ff << 1;
         bmag_ff <= bmag_ff >> 1;
      end
      if (cmd.save_den) den_ff <= acc_ff[DEN_W-1:0];
      if (cmd.save_ni)  ni_ff  <= acc_ff;
      if (cmd.div_load) begin
         dvd_ff    <= DIV_W'(nmag) << (cmd.div_sel ? 16 : 8);
         dneg_ff   <= num[ACC_W-1];
         rem_ff    <= '0;
         q_ff      <= '0;
         sticky_ff <= 1'b0;
      end else if (cmd.div_step) begin
         dvd_ff    <= dvd_ff << 1;
         rem_ff    <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         q_ff      <= {q_ff[Q_W-2:0], qbit};
         sticky_ff <= sticky_ff | q_ff[Q_W-1];
      end
      if (cmd.div_save) begin
         if (cmd.div_sel) slp_ff <= qres;
         else icpt_ff <= qres;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) sat_ff <= 1'b0;
      else if (cmd.div_save && qovf) sat_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (cmd.finish) rv_ff <= 1'b1;
      else if (!rsp_stall) rv_ff <= 1'b0;
      if (cmd.finish) begin
         ri_ff  <= (den_ff == '0) ? 32'd0 : icpt_ff;
         rs_ff  <= (den_ff == '0) ? 32'd0 : slp_ff;
         rst_ff <= status;
      end
   end

   assign stat.mac_busy = (bmag_ff != '0);
   assign stat.den_zero = (den_ff == '0);

   assign rsp_valid      = rv_ff;
   assign rsp_intercept  = ri_ff;
   assign rsp_slope      = rs_ff;
   assign rsp_fit_status = rst_ff;

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above capacity");
   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rst_ff == ST_ZERO_DEN |-> ri_ff == 32'd0 && rs_ff == 32'd0)
      else $error("zero denominator with nonzero result");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> cnt_ff == '0 && sx_ff == '0 && sxx_ff == '0 && !ovf_ff)
      else $error("sums not cleared after fit");

endmodule
